>>> rtl/mavf_pkg.sv
// ----------------------------------------------------------------------------
// mavf_pkg
// Shared types and constants for the moving-average filter core.
// ----------------------------------------------------------------------------
package mavf_pkg;

   // bits per byte lane of a stream data bus
   localparam int BYTE_BITS = 8;

   // window length after reset, before any CSR write
   localparam int LEN_RESET = 4;

   // sequencer states of the core
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIV,
      ST_OUT
   } mavf_state_type;

endpackage

>>> rtl/mavf_history.sv
// ----------------------------------------------------------------------------
// mavf_history
// Sample history ring: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mavf_history import mavf_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write the newest sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read the oldest sample, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mavf_divider.sv
// ----------------------------------------------------------------------------
// mavf_divider
// Signed-by-unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mavf_divider import mavf_pkg::*; #(
   parameter int DW = 23,
   parameter int VW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] dividend,
   input  logic [VW-1:0]        divisor,
   output logic                 done,
   output logic signed [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff,  busy_in;
   logic          done_ff,  done_in;
   logic [CW-1:0] count_ff, count_in;
   logic          neg_ff,   neg_in;
   logic [DW-1:0] mag_ff,   mag_in;
   logic [VW-1:0] rem_ff,   rem_in;
   logic [VW-1:0] dsr_ff,   dsr_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;

   // one restoring step: shift in the next dividend bit, try a subtract
   assign trial = {rem_ff, mag_ff[DW-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(DW);
         neg_in   = dividend[DW-1];
         mag_in   = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[VW-1:0];
            mag_in = {mag_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            mag_in = {mag_ff[DW-2:0], 1'b0};
         end
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   // restore the sign of the quotient
   assign done     = done_ff;
   assign quotient = neg_ff ? $signed(-mag_ff) : $signed(mag_ff);

endmodule

>>> rtl/moving_average_filter_core.sv
// ----------------------------------------------------------------------------
// moving_average_filter_core
// Moving-average filter over a stream of signed samples.
// ----------------------------------------------------------------------------
// The core keeps the last window_length samples in a ring and their running
// sum. Until the window is full each sample is passed through with
// warming_up set; after that each result is the average of the previous
// window_length samples, truncated toward zero, and the window slides. A
// sample with tlast set ends a record: with a full window its result
// includes that sample, and the stream state is cleared either way.
// Samples are taken one at a time. A passed-through sample goes from the
// FETCH state to OUT; an averaged one goes from FETCH through DIV, where
// the bit-serial divider produces one quotient bit per cycle, to OUT.
// The next sample can transfer in the cycle after the result is loaded into
// the output register. A result waiting in the output register does not
// block the next input transfer; the next result waits in the sequencer
// until the output register drains. csr_wdata takes effect as window
// length (0 acts as 1, values above WINDOW_MAX as WINDOW_MAX) and clears
// the stream state; write it only while idle.
// ----------------------------------------------------------------------------
module moving_average_filter_core import mavf_pkg::*; #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   // input sample stream
   input  logic req_tvalid,
   output logic req_tready,
   // [SAMPLE_WIDTH-1:0] sample, zero padding above
   input  logic [((SAMPLE_WIDTH+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS-1:0] req_tdata,
   input  logic req_tlast,     // final_sample
   // result stream
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [SAMPLE_WIDTH-1:0] filtered, zero padding above
   output logic [((SAMPLE_WIDTH+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS-1:0] rsp_tdata,
   output logic rsp_tuser,     // warming_up
   // window length register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_wdata
);

   localparam int TDATA_W = ((SAMPLE_WIDTH + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
   localparam int AW      = $clog2(WINDOW_MAX);
   localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W   = SAMPLE_WIDTH + AW + 1;
   localparam int PW      = LEN_W + 1;
   localparam int LEN_RST = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

   mavf_state_type state_ff, state_in;

   logic [LEN_W-1:0]               len_ff,   len_in;
   logic [AW-1:0]                  wp_ff,    wp_in;
   logic [LEN_W-1:0]               fill_ff,  fill_in;
   logic signed [SUM_W-1:0]        sum_ff,   sum_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff,     x_in;
   logic                           last_ff,  last_in;
   logic signed [SAMPLE_WIDTH-1:0] res_ff,   res_in;
   logic                           warm_ff,  warm_in;
   logic                           ovalid_ff, ovalid_in;
   logic signed [SAMPLE_WIDTH-1:0] odata_ff, odata_in;
   logic                           ouser_ff, ouser_in;

   logic                           req_xfer;
   logic                           csr_xfer;
   logic [LEN_W-1:0]               len_clamped;
   logic [PW-1:0]                  wp_ext;
   logic [PW-1:0]                  len_ext;
   logic [PW-1:0]                  oldest_pos;
   logic [AW-1:0]                  wp_next;
   logic                           full;
   logic                           full_with_x;
   logic signed [SAMPLE_WIDTH-1:0] ring_rd;
   logic signed [SUM_W-1:0]        oldest;
   logic signed [SUM_W-1:0]        slid_sum;
   logic                           ring_we;
   logic                           div_start;
   logic signed [SUM_W-1:0]        div_dividend;
   logic                           div_done;
   logic signed [SUM_W-1:0]        div_quot;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign csr_xfer   = csr_valid & csr_ready;

   // clamp the written window length into 1..WINDOW_MAX
   always_comb begin
      if (csr_wdata == 7'd0) begin
         len_clamped = LEN_W'(1);
      end else if (32'(csr_wdata) > 32'(WINDOW_MAX)) begin
         len_clamped = LEN_W'(WINDOW_MAX);
      end else begin
         len_clamped = LEN_W'(csr_wdata);
      end
   end

   // ring address of the sample that leaves the window
   assign wp_ext  = PW'(wp_ff);
   assign len_ext = PW'(len_ff);
   always_comb begin
      if (wp_ext >= len_ext) begin
         oldest_pos = wp_ext - len_ext;
      end else begin
         oldest_pos = wp_ext + PW'(WINDOW_MAX) - len_ext;
      end
   end

   assign wp_next     = (wp_ff == AW'(WINDOW_MAX - 1)) ? '0 : wp_ff + AW'(1);
   assign full        = (fill_ff >= len_ff);
   assign full_with_x = (PW'(fill_ff) + PW'(1) >= len_ext);
   assign oldest      = full ? SUM_W'(ring_rd) : '0;
   assign slid_sum    = sum_ff - oldest + SUM_W'(x_ff);
   assign ring_we     = (state_ff == ST_FETCH) && !last_ff;

   mavf_history #(
      .DEPTH (WINDOW_MAX),
      .WIDTH (SAMPLE_WIDTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_en   (req_xfer),
      .rd_addr (oldest_pos[AW-1:0]),
      .rd_data (ring_rd)
   );

   mavf_divider #(
      .DW (SUM_W),
      .VW (LEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // sequencer: next state, stream state updates and result staging
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      res_in       = res_ff;
      warm_in      = warm_ff;
      ovalid_in    = ovalid_ff;
      odata_in     = odata_ff;
      ouser_in     = ouser_ff;
      div_start    = 1'b0;
      div_dividend = sum_ff;

      // drop the output once transferred
      if (rsp_tready) begin
         ovalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_xfer) begin
               len_in  = len_clamped;
               wp_in   = '0;
               fill_in = '0;
               sum_in  = '0;
            end
            if (req_xfer) begin
               x_in     = req_tdata[SAMPLE_WIDTH-1:0];
               last_in  = req_tlast;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            res_in  = x_ff;
            warm_in = 1'b1;
            if (last_ff) begin
               // end of record: average including this sample once it fills the window, then clear
               if (full_with_x) begin
                  div_start    = 1'b1;
                  div_dividend = slid_sum;
               end
               wp_in   = '0;
               fill_in = '0;
               sum_in  = '0;
            end else begin
               if (full) begin
                  div_start    = 1'b1;
                  div_dividend = sum_ff;
                  sum_in       = slid_sum;
               end else begin
                  sum_in  = sum_ff + SUM_W'(x_ff);
                  fill_in = fill_ff + LEN_W'(1);
               end
               wp_in = wp_next;
            end
            state_in = div_start ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = div_quot[SAMPLE_WIDTH-1:0];
               warm_in  = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the output register once it is free
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               odata_in  = res_ff;
               ouser_in  = warm_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         len_ff    <= LEN_W'(LEN_RST);
         wp_ff     <= '0;
         fill_ff   <= '0;
         sum_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      last_ff  <= last_in;
      res_ff   <= res_in;
      warm_ff  <= warm_in;
      odata_ff <= odata_in;
      ouser_ff <= ouser_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = TDATA_W'($unsigned(odata_ff));
   assign rsp_tuser  = ouser_ff;

endmodule

>>> rtl/mavf_checker.sv
// ----------------------------------------------------------------------------
// mavf_checker
// Port-level checks on the moving-average filter core, bound to the top.
// ----------------------------------------------------------------------------
module mavf_checker import mavf_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((SAMPLE_WIDTH+BYTE_BITS-1)/BYTE_BITS)*BYTE_BITS-1:0] rsp_tdata,
   input logic rsp_tuser,
   input logic csr_ready
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one sample at a time: busy right after an input transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a sample is in work");

   // a result never appears in the cycle right after an input transfer
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

   // register writes only while no sample is in work
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> req_tready)
      else $error("csr open while busy");

endmodule

bind moving_average_filter_core mavf_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mavf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);
